/* hw/rtl/hvt_pkg.sv */
// ----------------------------------------------------------------------------
// hvt_pkg
// Types, constants and helpers shared by the vertex transform pipeline.
// ----------------------------------------------------------------------------
package hvt_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS  = 12;

    localparam int POS_W     = 32;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_N     = 8;
    localparam int CFG_IDX_W = 4;
    localparam int PROD_W    = POS_W + COEF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MAG_W     = SUM_W - 1;
    localparam int QUO_W     = 32;
    localparam int DIV_SH    = QUO_W - COORD_FRAC_BITS;
    localparam int DIV_STEPS = QUO_W;
    localparam int NSTG      = 1 + 2 + 2 + DIV_STEPS + 1;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_N] = '{
        32'h0000_1000, 32'h0000_0000, 32'h1000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_1000, 32'h0000_0000, 32'h1000_0000
    };

    // divisor standing in for a zero w: gives a plain shift by COEF_FRAC_BITS
    localparam logic [MAG_W-1:0] WZERO_DIV = MAG_W'(1) << (COEF_FRAC_BITS + COORD_FRAC_BITS);

    localparam logic [QUO_W-1:0] POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] NEG_MIN = {1'b1, {(QUO_W-1){1'b0}}};

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [POS_W-1:0] out_z;
        logic                    w_was_zero;
        logic                    saturated;
    } t_out;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] word;
        logic             neg;
        logic             ovf;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [2:0]  lane;
        logic [MAG_W-1:0] dvs;
        logic             wz;
    } t_div_item;

    function automatic t_div_lane div_step(t_div_lane l, logic [MAG_W-1:0] d);
        logic [MAG_W:0] t;
        t_div_lane      r;
        t = {l.rem, l.word[QUO_W-1]};
        r = l;
        if (t >= {1'b0, d}) begin
            r.rem  = MAG_W'(t - {1'b0, d});
            r.word = {l.word[QUO_W-2:0], 1'b1};
        end else begin
            r.rem  = t[MAG_W-1:0];
            r.word = {l.word[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* hw/rtl/hvt_mul.sv */
// ----------------------------------------------------------------------------
// hvt_mul
// Product stage: the twelve point-by-coefficient products, registered.
// ----------------------------------------------------------------------------
module hvt_mul import hvt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  t_in                      i_data,
    input  t_coef                    i_coef [4][4],
    output logic signed [PROD_W-1:0] o_prod [3][4],
    output t_coef                    o_trans [4]
);
    logic signed [PROD_W-1:0] r_prod  [3][4];
    t_coef                    r_trans [4];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_prod[0][c] <= PROD_W'(i_data.pos_x) * PROD_W'(i_coef[0][c]);
                r_prod[1][c] <= PROD_W'(i_data.pos_y) * PROD_W'(i_coef[1][c]);
                r_prod[2][c] <= PROD_W'(i_data.pos_z) * PROD_W'(i_coef[2][c]);
                r_trans[c]   <= i_coef[3][c];
            end
        end
    end

    assign o_prod  = r_prod;
    assign o_trans = r_trans;
endmodule

/* hw/rtl/hvt_sum.sv */
// ----------------------------------------------------------------------------
// hvt_sum
// Two-stage adder tree giving the four column sums.
// ----------------------------------------------------------------------------
module hvt_sum import hvt_pkg::*; (
    input  logic                     i_clk,
    input  logic [1:0]               i_en,
    input  logic signed [PROD_W-1:0] i_prod [3][4],
    input  t_coef                    i_trans [4],
    output logic signed [SUM_W-1:0]  o_sum [4]
);
    logic signed [SUM_W-1:0] r_pa [4];
    logic signed [SUM_W-1:0] r_pb [4];
    logic signed [SUM_W-1:0] r_sum [4];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            if (i_en[0]) begin
                r_pa[c] <= SUM_W'(i_prod[0][c]) + SUM_W'(i_prod[1][c]);
                r_pb[c] <= SUM_W'(i_prod[2][c]) + $signed({
                    {(SUM_W-COEF_W-COORD_FRAC_BITS){i_trans[c][COEF_W-1]}},
                    i_trans[c], {COORD_FRAC_BITS{1'b0}}});
            end
            if (i_en[1]) begin
                r_sum[c] <= r_pa[c] + r_pb[c];
            end
        end
    end

    assign o_sum = r_sum;
endmodule

/* hw/rtl/hvt_prep.sv */
// ----------------------------------------------------------------------------
// hvt_prep
// Magnitudes and signs, divisor choice, overflow check and divider setup.
// ----------------------------------------------------------------------------
module hvt_prep import hvt_pkg::*; (
    input  logic                    i_clk,
    input  logic [1:0]              i_en,
    input  logic signed [SUM_W-1:0] i_sum [4],
    output t_div_item               o_item
);
    logic [MAG_W-1:0] r_mag [4];
    logic [MAG_W-1:0] n_mag [4];
    logic             r_neg [4];
    logic             r_wz;
    t_div_item        r_item;
    t_div_item        n_item;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_mag[c] = i_sum[c][SUM_W-1] ? MAG_W'(-i_sum[c]) : i_sum[c][MAG_W-1:0];
        end
    end

    always_comb begin
        n_item.wz  = r_wz;
        n_item.dvs = r_wz ? WZERO_DIV : r_mag[3];
        for (int c = 0; c < 3; c++) begin
            n_item.lane[c].neg  = r_neg[c] ^ (r_neg[3] & ~r_wz);
            n_item.lane[c].ovf  = {{DIV_SH{1'b0}}, r_mag[c]} >= {n_item.dvs, {DIV_SH{1'b0}}};
            n_item.lane[c].rem  = {{DIV_SH{1'b0}}, r_mag[c][MAG_W-1:DIV_SH]};
            n_item.lane[c].word = {r_mag[c][DIV_SH-1:0], {COORD_FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int c = 0; c < 4; c++) begin
                r_neg[c] <= i_sum[c][SUM_W-1];
                r_mag[c] <= n_mag[c];
            end
            r_wz <= (i_sum[3] == '0);
        end
        if (i_en[1]) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule

/* hw/rtl/hvt_div.sv */
// ----------------------------------------------------------------------------
// hvt_div
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// ----------------------------------------------------------------------------
module hvt_div import hvt_pkg::*; (
    input  logic                 i_clk,
    input  logic [DIV_STEPS-1:0] i_en,
    input  t_div_item            i_item,
    output t_div_item            o_item
);
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        t_div_item src;
        t_div_item n_stg;
        t_div_item r_stg;
        if (k == 0) begin : g_first
            assign src = i_item;
        end else begin : g_rest
            assign src = g_step[k-1].r_stg;
        end
        always_comb begin
            n_stg = src;
            for (int l = 0; l < 3; l++) begin
                n_stg.lane[l] = div_step(src.lane[l], src.dvs);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_stg <= n_stg;
            end
        end
    end

    assign o_item = g_step[DIV_STEPS-1].r_stg;
endmodule

/* hw/rtl/hvt_out.sv */
// ----------------------------------------------------------------------------
// hvt_out
// Sign, saturation and the output register.
// ----------------------------------------------------------------------------
module hvt_out import hvt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_div_item i_item,
    output t_out      o_data
);
    t_out             r_out;
    t_out             n_out;
    logic [QUO_W-1:0] v [3];
    logic             s [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            s[l] = 1'b0;
            if (i_item.lane[l].ovf) begin
                s[l] = 1'b1;
                v[l] = i_item.lane[l].neg ? NEG_MIN : POS_MAX;
            end else if (i_item.lane[l].neg) begin
                if (i_item.lane[l].word > NEG_MIN) begin
                    s[l] = 1'b1;
                    v[l] = NEG_MIN;
                end else begin
                    v[l] = -i_item.lane[l].word;
                end
            end else if (i_item.lane[l].word[QUO_W-1]) begin
                s[l] = 1'b1;
                v[l] = POS_MAX;
            end else begin
                v[l] = i_item.lane[l].word;
            end
        end
        n_out.out_x      = $signed(v[0]);
        n_out.out_y      = $signed(v[1]);
        n_out.out_z      = $signed(v[2]);
        n_out.w_was_zero = i_item.wz;
        n_out.saturated  = s[0] | s[1] | s[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;
endmodule

/* hw/rtl/homogeneous_vertex_transform.sv */
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// Point times 4x4 matrix with perspective divide, fully pipelined.
// ----------------------------------------------------------------------------
// One item enters per cycle unless stalled at the input; it passes one product
// stage, two adder stages, two setup stages, 32 divider stages (one quotient
// bit each) and the output register. Stalls back up only to the first empty
// stage. A zero w divides by WZERO_DIV and is flagged; results saturate. Users
// must write Matrix registers via the plain write port while idle (unenforced).
module homogeneous_vertex_transform import hvt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data
);
    logic [CFG_W-1:0] r_cfg [CFG_N];
    t_coef            coef [4][4];
    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  en;

    logic signed [PROD_W-1:0] prod [3][4];
    t_coef                    trans [4];
    logic signed [SUM_W-1:0]  sum [4];
    t_div_item                prep_item;
    t_div_item                div_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_N; i++) r_cfg[i] <= CFG_RESET[i];
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(CFG_N))) begin
            r_cfg[i_cfg_idx[$clog2(CFG_N)-1:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                coef[r][c] = r_cfg[2*r + c/2][COEF_W*(c%2) +: COEF_W];
            end
        end
    end

    always_comb begin
        en[NSTG-1] = ~r_vld[NSTG-1] | i_out_ready;
        for (int k = NSTG-2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    hvt_mul u_mul (
        .i_clk   (i_clk),
        .i_en    (en[0]),
        .i_data  (i_in_data),
        .i_coef  (coef),
        .o_prod  (prod),
        .o_trans (trans)
    );

    hvt_sum u_sum (
        .i_clk   (i_clk),
        .i_en    (en[2:1]),
        .i_prod  (prod),
        .i_trans (trans),
        .o_sum   (sum)
    );

    hvt_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (en[4:3]),
        .i_sum  (sum),
        .o_item (prep_item)
    );

    hvt_div u_div (
        .i_clk  (i_clk),
        .i_en   (en[DIV_STEPS+4:5]),
        .i_item (prep_item),
        .o_item (div_item)
    );

    hvt_out u_out (
        .i_clk  (i_clk),
        .i_en   (en[NSTG-1]),
        .i_item (div_item),
        .o_data (o_out_data)
    );

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NSTG-1];

    a_ready_low_only_on_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && (&r_vld)))
        else $error("input stalled while pipeline has room");

    a_held_item_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("waiting result lost");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");
endmodule

/* tb/sv/tb_homogeneous_vertex_transform.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_homogeneous_vertex_transform
// Self-checking bench for the 4x4 point transform with perspective divide.
// Points are pushed through valid/ready with random gaps and output stalls.
// A behavioural model of the matrix product and divide predicts every result,
// which is then checked in order against the block's output. The matrix is
// reprogrammed between phases, including extremes and zero w.
// ----------------------------------------------------------------------------
module tb_homogeneous_vertex_transform;
    import hvt_pkg::*;

    localparam int DRAIN_CYC = 60;
    localparam int LIMIT_CYC = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out                 o_out_data;

    logic [CFG_W-1:0] matrix [CFG_N];
    t_out             expected_pts [$];
    int               n_err = 0;
    int               n_cyc = 0;
    int               hold_req = 0;
    bit               calm = 1'b0;
    bit               rx_on = 1'b0;

    homogeneous_vertex_transform dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        n_cyc <= n_cyc + 1;
        if (n_cyc > LIMIT_CYC) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint coef(int r, int c);
        logic [31:0] w;
        logic [15:0] h;
        w = matrix[2 * r + (c >> 1)];
        h = c[0] ? w[31:16] : w[15:0];
        return longint'($signed(h));
    endfunction

    function automatic longint unsigned frac_div(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = a / b;
        r = a % b;
        for (int i = 0; i < COORD_FRAC_BITS; i++) begin
            if (q >= (64'd1 << 40)) return 64'd1 << 40;
            q = q << 1;
            r = r << 1;
            if (r >= b) begin
                r = r - b;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic t_out transform_point(t_in p);
        longint          s [4];
        longint unsigned wmag;
        longint unsigned mag;
        longint unsigned q;
        logic [31:0]     v [3];
        bit              neg;
        bit              sat;
        t_out            o;
        sat = 1'b0;
        for (int c = 0; c < 4; c++)
            s[c] = longint'(p.pos_x) * coef(0, c) + longint'(p.pos_y) * coef(1, c)
                 + longint'(p.pos_z) * coef(2, c) + coef(3, c) * (64'sd1 <<< COORD_FRAC_BITS);
        wmag = s[3] < 0 ? -s[3] : s[3];
        for (int c = 0; c < 3; c++) begin
            mag = s[c] < 0 ? -s[c] : s[c];
            neg = s[c] < 0;
            if (s[3] == 0) begin
                q = mag >> COEF_FRAC_BITS;
            end else begin
                q = frac_div(mag, wmag);
                neg = neg != (s[3] < 0);
            end
            if (q == 0) neg = 1'b0;
            if (neg) begin
                if (q > 64'h8000_0000) begin
                    sat = 1'b1;
                    v[c] = 32'h8000_0000;
                end else begin
                    v[c] = 32'(-q);
                end
            end else if (q > 64'h7FFF_FFFF) begin
                sat = 1'b1;
                v[c] = 32'h7FFF_FFFF;
            end else begin
                v[c] = q[31:0];
            end
        end
        o.out_x = v[0];
        o.out_y = v[1];
        o.out_z = v[2];
        o.w_was_zero = (s[3] == 0);
        o.saturated = sat;
        return o;
    endfunction

    // output checker
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pts.size() == 0) begin
                $error("unexpected item %h", o_out_data);
                n_err++;
            end else begin
                e = expected_pts.pop_front();
                if (o_out_data.out_x !== e.out_x) begin
                    $error("out_x exp %h got %h", e.out_x, o_out_data.out_x);
                    n_err++;
                end
                if (o_out_data.out_y !== e.out_y) begin
                    $error("out_y exp %h got %h", e.out_y, o_out_data.out_y);
                    n_err++;
                end
                if (o_out_data.out_z !== e.out_z) begin
                    $error("out_z exp %h got %h", e.out_z, o_out_data.out_z);
                    n_err++;
                end
                if (o_out_data.w_was_zero !== e.w_was_zero) begin
                    $error("w_was_zero exp %b got %b", e.w_was_zero, o_out_data.w_was_zero);
                    n_err++;
                end
                if (o_out_data.saturated !== e.saturated) begin
                    $error("saturated exp %b got %b", e.saturated, o_out_data.saturated);
                    n_err++;
                end
            end
        end
    end

    // receiver: random stall bursts, plus a long hold on request
    initial begin
        int burst;
        forever begin
            @(negedge i_clk);
            if (!rx_on) begin
                i_out_ready <= 1'b0;
            end else if (hold_req > 0) begin
                i_out_ready <= 1'b0;
                hold_req--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 4);
                i_out_ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_point(t_in p);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (!o_in_ready);
        expected_pts.push_back(transform_point(p));
        if (!calm && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_pts.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= val;
        if (idx < CFG_N) matrix[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2 ** 20)) - (2 ** 19));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_matrix(bit zero_w);
        for (int i = 0; i < CFG_N; i++)
            write_reg(i, {zero_w && i[0] ? 16'h0000 : rand_coef(), rand_coef()});
    endtask

    task automatic random_points(int n);
        t_in p;
        repeat (n) begin
            p.pos_x = rand_coord();
            p.pos_y = rand_coord();
            p.pos_z = rand_coord();
            send_point(p);
        end
    endtask

    task automatic test_identity_extremes();
        logic [31:0] vals [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
        for (int i = 0; i < 5; i++)
            send_point(t_in'{vals[i], vals[(i + 1) % 5], vals[(i + 2) % 5]});
        settle();
    endtask

    task automatic test_zero_w();
        write_reg(1, 32'h0000_7FFF);
        write_reg(3, 32'h0000_8000);
        write_reg(5, 32'h0000_1000);
        write_reg(7, 32'h0000_1000);
        send_point(t_in'{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678});
        send_point(t_in'{32'h0, 32'h0, 32'h0});
        send_point(t_in'{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000});
        settle();
    endtask

    task automatic test_huge_quotient();
        write_reg(0, 32'h0000_7FFF);
        write_reg(2, 32'h0000_8000);
        write_reg(4, 32'h0000_7FFF);
        write_reg(1, 32'h0001_0000);
        write_reg(3, 32'h0000_0000);
        write_reg(5, 32'h0000_0000);
        write_reg(7, 32'h0000_0000);
        write_reg(6, 32'h0000_8000);
        send_point(t_in'{32'h7FFF_FFFF, 32'h0, 32'h0});
        send_point(t_in'{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        send_point(t_in'{32'h0000_0001, 32'hFFFF_FFFF, 32'h0});
        settle();
        write_reg(7, 32'hFFFF_8000);
        send_point(t_in'{32'h0012_3456, 32'hFFFE_0000, 32'h0004_0000});
        settle();
    endtask

    task automatic test_bad_index();
        for (int i = CFG_N; i < 2 ** CFG_IDX_W; i++) write_reg(i, $urandom);
        send_point(t_in'{32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000});
        send_point(t_in'{32'h4000_0000, 32'hC000_0000, 32'h0000_0001});
        settle();
    endtask

    task automatic test_backpressure();
        random_matrix(1'b0);
        hold_req = 150;
        random_points(100);
        settle();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            random_matrix(ph == 2);
            if (ph == 5) calm = 1'b1;
            random_points(140);
            settle();
        end
    endtask

    initial begin
        for (int i = 0; i < CFG_N; i++) matrix[i] = CFG_RESET[i];
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        rx_on = 1'b1;
        test_identity_extremes();
        test_zero_w();
        test_huge_quotient();
        test_bad_index();
        test_backpressure();
        test_random();
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
